// File: rtl/intel_hex_record_parser_unit_assert.svh
// Assertion macros shared by the RTL of the Intel HEX record parser.
// Every macro samples on the rising edge of clock and is disabled during reset.
`ifndef INTEL_HEX_RECORD_PARSER_UNIT_ASSERT_SVH
`define INTEL_HEX_RECORD_PARSER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IHEX_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IHEX_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/ihex_pkg.sv
`timescale 1ns / 1ps

package ihex_pkg;

   // Fixed line geometry.
   localparam logic [9:0] COUNT_MAX = 10'd1023;
   localparam logic [9:0] MIN_LINE  = 10'd11;
   localparam logic [7:0] START_CODE = 8'h3A;  // ASCII colon
   localparam logic [19:0] SEG_MASK = 20'hFFFFF;

   // Record type codes as they appear in the type byte.
   localparam logic [7:0] TYPE_DATA     = 8'd0;
   localparam logic [7:0] TYPE_EOF      = 8'd1;
   localparam logic [7:0] TYPE_EXT_SEG  = 8'd2;
   localparam logic [7:0] TYPE_SEG_ENT  = 8'd3;
   localparam logic [7:0] TYPE_EXT_LIN  = 8'd4;
   localparam logic [7:0] TYPE_LIN_ENT  = 8'd5;

   // Result kinds carried on tuser.
   localparam logic KIND_DATA   = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   typedef enum logic [2:0] {
      STATUS_OK         = 3'd0,
      STATUS_NO_COLON   = 3'd1,
      STATUS_TOO_SHORT  = 3'd2,
      STATUS_LEN_MISMATCH = 3'd3,
      STATUS_BAD_TYPE   = 3'd4,
      STATUS_CHECKSUM   = 3'd5,
      STATUS_BAD_HEX    = 3'd6
   } status_type;

   typedef enum logic [1:0] {
      RKIND_DATA    = 2'd0,
      RKIND_EOF     = 2'd1,
      RKIND_EXT_ADDR = 2'd2,
      RKIND_ENTRY   = 2'd3
   } record_kind_type;

   // Per-line decode state; all of it clears at end of line.
   typedef struct packed {
      logic [9:0]  char_count;
      logic [3:0]  high_nibble;
      logic [7:0]  declared_length;
      logic [15:0] record_offset;
      logic [7:0]  record_type_code;
      logic [7:0]  running_sum;
      logic [31:0] payload_word;
      status_type  first_error;
   } line_state_type;

   // End-of-record evaluation handed back to the top level.
   typedef struct packed {
      status_type      status;
      record_kind_type record_kind;
      logic [31:0]     address;
      logic [7:0]      length;
      logic            base_load;
      logic [31:0]     new_base;
   } eval_result_type;

endpackage

// File: rtl/ihex_record_eval.sv
`timescale 1ns / 1ps

module ihex_record_eval
   import ihex_pkg::*;
(
   input  line_state_type  line,
   input  logic [31:0]     base_address,
   output eval_result_type result
);

   // Status checks in order of precedence, then the record summary for a good line.
   always_comb begin
      logic [9:0]  expected_count;
      logic [7:0]  need_length;
      logic [19:0] seg_entry;
      status_type  st;

      expected_count = {1'b0, line.declared_length, 1'b0} + MIN_LINE;

      case (line.record_type_code)
         TYPE_DATA:    need_length = line.declared_length;
         TYPE_EOF:     need_length = 8'd0;
         TYPE_EXT_SEG: need_length = 8'd2;
         TYPE_EXT_LIN: need_length = 8'd2;
         default:      need_length = 8'd4;
      endcase

      if ((line.char_count == 10'd0) || (line.first_error == STATUS_NO_COLON)) begin
         st = STATUS_NO_COLON;
      end else if (line.char_count < MIN_LINE) begin
         st = STATUS_TOO_SHORT;
      end else if (line.char_count != expected_count) begin
         st = STATUS_LEN_MISMATCH;
      end else if (line.first_error == STATUS_BAD_HEX) begin
         st = STATUS_BAD_HEX;
      end else if (line.record_type_code > TYPE_LIN_ENT) begin
         st = STATUS_BAD_TYPE;
      end else if (line.declared_length != need_length) begin
         st = STATUS_LEN_MISMATCH;
      end else if (line.running_sum != 8'd0) begin
         st = STATUS_CHECKSUM;
      end else begin
         st = STATUS_OK;
      end

      // Segment entry point: CS * 16 + IP, wrapped to 20 bits.
      seg_entry = ({line.payload_word[31:16], 4'd0} + {4'd0, line.payload_word[15:0]})
                  & SEG_MASK;

      result.status      = st;
      result.record_kind = RKIND_DATA;
      result.address     = 32'd0;
      result.length      = 8'd0;
      result.base_load   = 1'b0;
      result.new_base    = 32'd0;

      if (st == STATUS_OK) begin
         result.length = line.declared_length;
         case (line.record_type_code)
            TYPE_DATA: begin
               result.address = base_address + {16'd0, line.record_offset};
            end
            TYPE_EOF: begin
               result.record_kind = RKIND_EOF;
            end
            TYPE_EXT_SEG: begin
               result.record_kind = RKIND_EXT_ADDR;
               result.new_base    = {12'd0, line.payload_word[15:0], 4'd0};
               result.base_load   = 1'b1;
               result.address     = result.new_base;
            end
            TYPE_EXT_LIN: begin
               result.record_kind = RKIND_EXT_ADDR;
               result.new_base    = {line.payload_word[15:0], 16'd0};
               result.base_load   = 1'b1;
               result.address     = result.new_base;
            end
            TYPE_SEG_ENT: begin
               result.record_kind = RKIND_ENTRY;
               result.address     = {12'd0, seg_entry};
            end
            default: begin
               result.record_kind = RKIND_ENTRY;
               result.address     = line.payload_word;
            end
         endcase
      end
   end

endmodule

// File: rtl/intel_hex_record_parser_unit.sv
// A result is valid on rsp_ in the cycle after the transaction that causes it.
// Throughput: one character or end-of-line transaction per cycle unless rsp_tready stalls;
// the single state update stage feeding the result register sets this figure.
// Reset: synchronous, active high; clears the line state, the base address and
// the result valid flag.
`timescale 1ns / 1ps
`include "intel_hex_record_parser_unit_assert.svh"

module intel_hex_record_parser_unit
   import ihex_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] ch
   input  logic        req_tlast,   // end_of_line
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // [31:0] address, [39:32] data_byte, [42:40] status,
                                    // [44:43] record_kind, [52:45] length, [55:53] zero
   output logic        rsp_tuser    // [0] kind
);

   // Hex digit decode; a flag marks anything that is not a hex digit.
   function automatic logic [4:0] hex_decode(input logic [7:0] c);
      logic [4:0] r;
      if ((c >= 8'h30) && (c <= 8'h39)) begin
         r = {1'b0, 4'(c - 8'h30)};
      end else if ((c >= 8'h41) && (c <= 8'h46)) begin
         r = {1'b0, 4'(c - 8'h37)};
      end else if ((c >= 8'h61) && (c <= 8'h66)) begin
         r = {1'b0, 4'(c - 8'h57)};
      end else begin
         r = 5'b10000;
      end
      return r;
   endfunction

   line_state_type  line_ff, line_in;
   logic [31:0]     base_address_ff, base_address_in;
   eval_result_type eval;

   logic            rsp_valid_ff, rsp_valid_in;
   logic            rsp_kind_ff, rsp_kind_in;
   logic [31:0]     rsp_address_ff, rsp_address_in;
   logic [7:0]      rsp_data_byte_ff, rsp_data_byte_in;
   status_type      rsp_status_ff, rsp_status_in;
   record_kind_type rsp_record_kind_ff, rsp_record_kind_in;
   logic [7:0]      rsp_length_ff, rsp_length_in;

   logic            accept;
   logic            emit_data;

   // The result register frees itself when taken, so a new transaction can enter.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   ihex_record_eval u_eval (
      .line         (line_ff),
      .base_address (base_address_ff),
      .result       (eval)
   );

   // Per-character decode and the end-of-line summary.
   always_comb begin
      logic [9:0] pos;
      logic [4:0] nib;
      logic [7:0] v;
      logic [8:0] b;
      logic [8:0] k;

      pos = line_ff.char_count;
      nib = hex_decode(req_tdata);
      v   = {line_ff.high_nibble, nib[3:0]};
      b   = pos[9:1] - 9'd1;
      k   = b - 9'd4;

      line_in            = line_ff;
      base_address_in    = base_address_ff;
      emit_data          = 1'b0;
      rsp_valid_in       = rsp_valid_ff && !rsp_tready;
      rsp_kind_in        = rsp_kind_ff;
      rsp_address_in     = rsp_address_ff;
      rsp_data_byte_in   = rsp_data_byte_ff;
      rsp_status_in      = rsp_status_ff;
      rsp_record_kind_in = rsp_record_kind_ff;
      rsp_length_in      = rsp_length_ff;

      if (accept) begin
         if (req_tlast) begin
            // End of line: report the record and start a fresh line.
            rsp_valid_in       = 1'b1;
            rsp_kind_in        = KIND_STATUS;
            rsp_address_in     = eval.address;
            rsp_data_byte_in   = 8'd0;
            rsp_status_in      = eval.status;
            rsp_record_kind_in = eval.record_kind;
            rsp_length_in      = eval.length;
            if (eval.base_load) begin
               base_address_in = eval.new_base;
            end
            line_in = '0;
         end else if (pos != COUNT_MAX) begin
            line_in.char_count = pos + 10'd1;
            if (pos == 10'd0) begin
               if ((req_tdata != START_CODE) && (line_ff.first_error == STATUS_OK)) begin
                  line_in.first_error = STATUS_NO_COLON;
               end
            end else begin
               if (nib[4] && (line_ff.first_error == STATUS_OK)) begin
                  line_in.first_error = STATUS_BAD_HEX;
               end
               if (pos[0]) begin
                  line_in.high_nibble = nib[3:0];
               end else begin
                  // A full byte: add it to the checksum and place it by position.
                  line_in.running_sum = line_ff.running_sum + v;
                  case (b)
                     9'd0:    line_in.declared_length = v;
                     9'd1:    line_in.record_offset   = {v, 8'd0};
                     9'd2:    line_in.record_offset   = {line_ff.record_offset[15:8], v};
                     9'd3:    line_in.record_type_code = v;
                     default: begin
                        if (k < {1'b0, line_ff.declared_length}) begin
                           if (k[8:2] == 7'd0) begin
                              line_in.payload_word = {line_ff.payload_word[23:0], v};
                           end
                           if ((line_in.first_error == STATUS_OK) &&
                               (line_ff.record_type_code == TYPE_DATA)) begin
                              emit_data = 1'b1;
                           end
                        end
                     end
                  endcase
               end
            end
         end

         // Tentative data byte of a data record.
         if (emit_data) begin
            rsp_valid_in       = 1'b1;
            rsp_kind_in        = KIND_DATA;
            rsp_address_in     = base_address_ff + {16'd0, line_ff.record_offset}
                                 + {23'd0, k};
            rsp_data_byte_in   = v;
            rsp_status_in      = STATUS_OK;
            rsp_record_kind_in = RKIND_DATA;
            rsp_length_in      = 8'd0;
         end
      end
   end

   // Control and line state.
   always_ff @(posedge clock) begin
      if (reset) begin
         line_ff         <= '0;
         base_address_ff <= 32'd0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         line_ff         <= line_in;
         base_address_ff <= base_address_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // Result payload register.
   always_ff @(posedge clock) begin
      rsp_kind_ff        <= rsp_kind_in;
      rsp_address_ff     <= rsp_address_in;
      rsp_data_byte_ff   <= rsp_data_byte_in;
      rsp_status_ff      <= rsp_status_in;
      rsp_record_kind_ff <= rsp_record_kind_in;
      rsp_length_ff      <= rsp_length_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = {3'd0, rsp_length_ff, rsp_record_kind_ff, rsp_status_ff,
                        rsp_data_byte_ff, rsp_address_ff};

   // A failed record reports nothing but its status.
   `IHEX_ASSERT_SAME(a_fail_fields_zero, rsp_valid_ff && (rsp_kind_ff == KIND_STATUS) && (rsp_status_ff != STATUS_OK), (rsp_address_ff == 32'd0) && (rsp_length_ff == 8'd0) && (rsp_record_kind_ff == RKIND_DATA), "failed status carries nonzero fields")
   // A tentative data byte carries no status information.
   `IHEX_ASSERT_SAME(a_data_no_status, rsp_valid_ff && (rsp_kind_ff == KIND_DATA), (rsp_status_ff == STATUS_OK) && (rsp_length_ff == 8'd0), "data result carries status fields")
   // End of line restarts the line state.
   `IHEX_ASSERT_NEXT(a_eol_clears, accept && req_tlast, (line_ff.char_count == 10'd0) && (line_ff.running_sum == 8'd0), "line state not cleared after end of line")
   // No byte is released once the line has a character error.
   `IHEX_ASSERT_SAME(a_no_emit_on_error, line_ff.first_error != STATUS_OK, !emit_data, "data byte emitted after a character error")

endmodule
